>>> hdl/sefe_pkg.sv
// Shared constants, request descriptor type and stuffing helpers for the frame encoder.
package sefe_pkg;

  localparam logic [7:0] CODE_STX = 8'h02;
  localparam logic [7:0] CODE_ETX = 8'h03;
  localparam logic [7:0] CODE_DLE = 8'h10;
  localparam logic [7:0] CODE_DC2 = 8'h12;
  localparam logic [7:0] CODE_DC3 = 8'h13;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  // One classified request handed from the front to the back.
  typedef struct packed {
    logic       need_stx;
    logic [7:0] data;
    logic       data_esc;
    logic       last;
    logic [7:0] sum;
    logic       sum_esc;
  } desc_t;

  function automatic logic needs_escape(input logic [7:0] b);
    needs_escape = (b == CODE_STX) || (b == CODE_ETX) || (b == CODE_DLE);
  endfunction

  // Second byte of an escape pair.
  function automatic logic [7:0] escape_code(input logic [7:0] b);
    logic [7:0] r;
    r = CODE_DLE;
    if (b == CODE_STX) begin
      r = CODE_DC2;
    end else if (b == CODE_ETX) begin
      r = CODE_DC3;
    end
    escape_code = r;
  endfunction

endpackage

>>> hdl/stx_etx_dle_frame_encoder.sv
// Top level of the STX/ETX/DLE byte-stuffing frame encoder with additive checksum.
// Each payload request yields 1 to 6 line bytes (STX, stuffed byte, stuffed sum, ETX);
// the back end emits one line byte per cycle while a descriptor is queued and its
// output register is empty or popped. The front end accepts a new request every cycle
// while the descriptor queue (QueueDepth entries) has room; results wait in a single
// output register and are held until popped.
module stx_etx_dle_frame_encoder #(
  parameter int unsigned QueueDepth = sefe_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] payload_byte_i,
  input  logic       frame_last_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] line_byte_o,
  output logic       run_last_o,
  output logic       frame_end_o
);
  import sefe_pkg::*;

  desc_t front_desc, head_desc;
  logic  take, q_empty, done;

  assign take = push && !full;

  sefe_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (take),
    .payload_byte_i (payload_byte_i),
    .frame_last_i   (frame_last_i),
    .desc_o         (front_desc)
  );

  sefe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (take),
    .wr_data_i (front_desc),
    .full_o    (full),
    .rd_i      (done),
    .rd_data_o (head_desc),
    .empty_o   (q_empty)
  );

  sefe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_i       (head_desc),
    .desc_valid_i (!q_empty),
    .desc_done_o  (done),
    .pop_i        (pop),
    .empty_o      (empty),
    .line_byte_o  (line_byte_o),
    .run_last_o   (run_last_o),
    .frame_end_o  (frame_end_o)
  );

endmodule

>>> hdl/sefe_front.sv
// Front end: accepts payload requests, tracks frame state and checksum, builds descriptors.
module sefe_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           take_i,
  input  logic [7:0]     payload_byte_i,
  input  logic           frame_last_i,
  output sefe_pkg::desc_t desc_o
);
  import sefe_pkg::*;

  logic       inside_q, inside_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] sum_new;

  assign sum_new = (inside_q ? sum_q : 8'h00) + payload_byte_i;

  always_comb begin
    desc_o.need_stx = !inside_q;
    desc_o.data     = payload_byte_i;
    desc_o.data_esc = needs_escape(payload_byte_i);
    desc_o.last     = frame_last_i;
    desc_o.sum      = sum_new;
    desc_o.sum_esc  = needs_escape(sum_new);
  end

  always_comb begin
    inside_d = inside_q;
    sum_d    = sum_q;
    if (take_i) begin
      inside_d = !frame_last_i;
      sum_d    = frame_last_i ? 8'h00 : sum_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      sum_q    <= 8'h00;
    end else begin
      inside_q <= inside_d;
      sum_q    <= sum_d;
    end
  end

endmodule

>>> hdl/sefe_queue.sv
// Short descriptor queue between the front and back ends.
module sefe_queue #(
  parameter int unsigned Depth = sefe_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  sefe_pkg::desc_t wr_data_i,
  output logic            full_o,
  input  logic            rd_i,
  output sefe_pkg::desc_t rd_data_o,
  output logic            empty_o
);
  import sefe_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  desc_t           mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == FullCnt);
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (do_rd) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

>>> hdl/sefe_back.sv
// Back end: expands descriptors into output-register line bytes, one per unstalled cycle.
module sefe_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sefe_pkg::desc_t desc_i,
  input  logic            desc_valid_i,
  output logic            desc_done_o,
  input  logic            pop_i,
  output logic            empty_o,
  output logic [7:0]      line_byte_o,
  output logic            run_last_o,
  output logic            frame_end_o
);
  import sefe_pkg::*;

  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_STX   = 3'd1;
  localparam logic [2:0] PH_DDLE  = 3'd2;
  localparam logic [2:0] PH_DATA  = 3'd3;
  localparam logic [2:0] PH_SDLE  = 3'd4;
  localparam logic [2:0] PH_SUM   = 3'd5;
  localparam logic [2:0] PH_ETX   = 3'd6;

  logic [2:0] ph_q, ph_d, cur_ph, first_ph, next_ph;
  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       rlast_q, rlast_d, fend_q, fend_d;
  logic       advance, done;

  assign first_ph = desc_i.need_stx ? PH_STX : (desc_i.data_esc ? PH_DDLE : PH_DATA);
  assign cur_ph   = (ph_q == PH_START) ? first_ph : ph_q;
  assign advance  = desc_valid_i && (!valid_q || pop_i);

  always_comb begin
    byte_d  = CODE_DLE;
    rlast_d = 1'b0;
    fend_d  = 1'b0;
    next_ph = PH_START;
    done    = 1'b0;
    unique case (cur_ph)
      PH_STX: begin
        byte_d  = CODE_STX;
        next_ph = desc_i.data_esc ? PH_DDLE : PH_DATA;
      end
      PH_DDLE: begin
        next_ph = PH_DATA;
      end
      PH_DATA: begin
        byte_d  = desc_i.data_esc ? escape_code(desc_i.data) : desc_i.data;
        rlast_d = !desc_i.last;
        done    = !desc_i.last;
        next_ph = desc_i.sum_esc ? PH_SDLE : PH_SUM;
      end
      PH_SDLE: begin
        next_ph = PH_SUM;
      end
      PH_SUM: begin
        byte_d  = desc_i.sum_esc ? escape_code(desc_i.sum) : desc_i.sum;
        next_ph = PH_ETX;
      end
      PH_ETX: begin
        byte_d  = CODE_ETX;
        rlast_d = 1'b1;
        fend_d  = 1'b1;
        done    = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  assign desc_done_o = advance && done;

  always_comb begin
    ph_d    = ph_q;
    valid_d = valid_q;
    if (pop_i && valid_q) begin
      valid_d = 1'b0;
    end
    if (advance) begin
      valid_d = 1'b1;
      ph_d    = done ? PH_START : next_ph;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      byte_q  <= byte_d;
      rlast_q <= rlast_d;
      fend_q  <= fend_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= PH_START;
      valid_q <= 1'b0;
    end else begin
      ph_q    <= ph_d;
      valid_q <= valid_d;
    end
  end

  assign empty_o     = !valid_q;
  assign line_byte_o = byte_q;
  assign run_last_o  = rlast_q;
  assign frame_end_o = fend_q;

endmodule

>>> hdl/sefe_checker.sv
// Port-level checker for the frame encoder, bound to the top level.
module sefe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [7:0] line_byte_o,
  input logic       run_last_o,
  input logic       frame_end_o
);
  import sefe_pkg::*;

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && frame_end_o) |-> run_last_o)
    else $error("frame end without run last");

  a_end_is_etx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && frame_end_o) |-> (line_byte_o == CODE_ETX))
    else $error("frame end byte is not ETX");

  a_etx_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (line_byte_o == CODE_ETX)) |-> frame_end_o)
    else $error("unstuffed ETX inside frame");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(line_byte_o) && $stable(run_last_o)))
    else $error("result changed while stalled");

endmodule

bind stx_etx_dle_frame_encoder sefe_checker u_sefe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .empty       (empty),
  .pop         (pop),
  .line_byte_o (line_byte_o),
  .run_last_o  (run_last_o),
  .frame_end_o (frame_end_o)
);

>>> test/tb_stx_etx_dle_frame_encoder.sv
// Self-checking testbench for the STX/ETX/DLE frame encoder: directed and randomized frames against a predictor.
module tb_stx_etx_dle_frame_encoder;
  import sefe_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned ItemsPerPhase = 26;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } request_t;

  typedef struct {
    logic [7:0] code;
    logic       run_last;
    logic       frame_end;
  } line_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] payload_byte_i = 8'h00;
  logic       frame_last_i = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] line_byte_o;
  logic       run_last_o;
  logic       frame_end_o;

  request_t payload_q[$];
  line_t    line_bytes_due[$];

  logic       frame_open = 1'b0;
  logic [7:0] frame_sum = 8'h00;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned n_errors = 0;
  int unsigned n_requests = 0;
  int unsigned n_line_bytes = 0;
  int unsigned n_frames = 0;
  int unsigned n_cycles = 0;

  stx_etx_dle_frame_encoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .payload_byte_i(payload_byte_i),
    .frame_last_i  (frame_last_i),
    .empty         (empty),
    .pop           (pop),
    .line_byte_o   (line_byte_o),
    .run_last_o    (run_last_o),
    .frame_end_o   (frame_end_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0d] MISMATCH: %s", n_cycles, msg);
    n_errors++;
  endtask

  task automatic add_line(input logic [7:0] code, input logic fend);
    line_t l;
    l.code = code;
    l.run_last = 1'b0;
    l.frame_end = fend;
    line_bytes_due.push_back(l);
  endtask

  task automatic add_stuffed(input logic [7:0] b);
    if (b == CODE_STX) begin
      add_line(CODE_DLE, 1'b0);
      add_line(CODE_DC2, 1'b0);
    end else if (b == CODE_ETX) begin
      add_line(CODE_DLE, 1'b0);
      add_line(CODE_DC3, 1'b0);
    end else if (b == CODE_DLE) begin
      add_line(CODE_DLE, 1'b0);
      add_line(CODE_DLE, 1'b0);
    end else begin
      add_line(b, 1'b0);
    end
  endtask

  // Line bytes one payload request produces; updates frame state.
  task automatic encode_request(input request_t r);
    if (!frame_open) begin
      add_line(CODE_STX, 1'b0);
      frame_open = 1'b1;
      frame_sum = 8'h00;
    end
    frame_sum = frame_sum + r.data;
    add_stuffed(r.data);
    if (r.last) begin
      add_stuffed(frame_sum);
      add_line(CODE_ETX, 1'b1);
      frame_open = 1'b0;
      frame_sum = 8'h00;
    end
    line_bytes_due[line_bytes_due.size() - 1].run_last = 1'b1;
  endtask

  task automatic queue_request(input logic [7:0] data, input logic last);
    request_t r;
    r.data = data;
    r.last = last;
    payload_q.push_back(r);
  endtask

  // Biased toward control codes and boundary values.
  function automatic logic [7:0] pick_byte();
    logic [7:0] specials[7];
    specials = '{CODE_STX, CODE_ETX, CODE_DLE, CODE_DC2, CODE_DC3, 8'h00, 8'hFF};
    if ($urandom_range(99) < 30) begin
      return specials[$urandom_range(6)];
    end
    return 8'($urandom_range(255));
  endfunction

  task automatic wait_drained();
    while (payload_q.size() != 0 || line_bytes_due.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d line bytes outstanding", n_cycles,
               line_bytes_due.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Driver
  always @(posedge clk_i) begin
    logic go;
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        encode_request(payload_q[0]);
        payload_q.pop_front();
        n_requests++;
      end
      go = 1'b0;
      if (payload_q.size() != 0) begin
        go = (push && full) || ($urandom_range(99) >= tx_idle_pct);
      end
      if (go) begin
        payload_byte_i <= payload_q[0].data;
        frame_last_i <= payload_q[0].last;
      end
      push <= go;
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    line_t e;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        n_line_bytes++;
        if (frame_end_o) begin
          n_frames++;
        end
        if (line_bytes_due.size() == 0) begin
          report_mismatch($sformatf("unexpected line byte %02h run_last=%0b frame_end=%0b",
                                    line_byte_o, run_last_o, frame_end_o));
        end else begin
          e = line_bytes_due.pop_front();
          if (line_byte_o !== e.code || run_last_o !== e.run_last ||
              frame_end_o !== e.frame_end) begin
            report_mismatch($sformatf(
              "got byte=%02h run_last=%0b frame_end=%0b, want byte=%02h run_last=%0b frame_end=%0b",
              line_byte_o, run_last_o, frame_end_o, e.code, e.run_last, e.frame_end));
          end
        end
      end
      pop <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  initial begin
    int unsigned idle_tab[4];
    int unsigned stall_tab[4];
    int unsigned cnt;
    int unsigned len;
    int unsigned drain;
    idle_tab = '{0, 68, 0, 30};
    stall_tab = '{0, 0, 68, 30};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: escaped bytes, single-byte frames, escaped and wrapping sums
    queue_request(CODE_STX, 1'b1);
    queue_request(CODE_ETX, 1'b1);
    queue_request(CODE_DLE, 1'b1);
    queue_request(8'h00, 1'b1);
    queue_request(8'hFF, 1'b1);
    queue_request(CODE_DC2, 1'b1);
    queue_request(CODE_DC3, 1'b1);
    queue_request(8'hFF, 1'b0);
    queue_request(8'hFF, 1'b0);
    queue_request(8'h05, 1'b1);
    queue_request(8'h08, 1'b0);
    queue_request(8'h08, 1'b1);
    queue_request(8'h01, 1'b0);
    queue_request(8'h01, 1'b1);
    queue_request(8'h80, 1'b0);
    queue_request(8'h80, 1'b1);
    queue_request(8'h7F, 1'b0);
    queue_request(8'h80, 1'b0);
    queue_request(8'h55, 1'b1);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      tx_idle_pct = idle_tab[p];
      rx_stall_pct = stall_tab[p];
      cnt = 0;
      while (cnt < ItemsPerPhase) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(20, 9) : $urandom_range(1, 5);
        for (int i = 1; i <= len; i++) begin
          queue_request(pick_byte(), i == len);
        end
        cnt += len;
      end
      wait_drained();
    end

    tx_idle_pct = 0;
    rx_stall_pct = 0;
    drain = 0;
    while (line_bytes_due.size() != 0 && drain < 1000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (20) @(posedge clk_i);
    if (line_bytes_due.size() != 0) begin
      report_mismatch($sformatf("%0d line bytes never arrived", line_bytes_due.size()));
    end

    $display("Encoded %0d payload bytes into %0d line bytes over %0d frames,",
             n_requests, n_line_bytes, n_frames);
    $display("under no idling, sender gaps, receiver stalls and both; %0d mismatches",
             n_errors);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
